// ===== rtl/core/point_segment_distance_top_macros.svh =====
// assertion macros shared by the point to segment distance block
`ifndef POINT_SEGMENT_DISTANCE_TOP_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_TOP_MACROS_SVH

// property that must hold at every clock edge out of reset
`define PSD_CHECK(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// implication checked at the same clock edge
`define PSD_IMPLY(lbl, cond, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) else $error(msg);

`endif

// ===== rtl/core/psd_pkg.sv =====
// package with widths, region codes and tag type of the point to segment distance block
`timescale 1ns / 1ps
`default_nettype none
package psd_pkg;
   localparam int COORD_W    = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int DOT_W      = PROD_W + 1;
   localparam int SQ_W       = 2 * COORD_W + 1;
   localparam int ABS_W      = PROD_W;
   localparam int HALF_W     = ABS_W / 2;
   localparam int NUM_W      = 2 * SQ_W;
   localparam int QUOT_W     = SQ_W;
   localparam int DIST_W     = COORD_W + 1;
   localparam int RAD_W      = 2 * DIST_W;
   localparam int REM_W      = DIST_W + 2;
   localparam int IN_DATA_W  = 6 * COORD_W;
   localparam int OUT_DATA_W = ((DIST_W + 7) / 8) * 8;
   localparam int OUT_USER_W = 3;

   typedef enum logic [1:0] {
      REGION_START = 2'd0,
      REGION_END   = 2'd1,
      REGION_SIDE  = 2'd2
   } psd_region_type;

   typedef struct packed {
      logic           degenerate;
      psd_region_type region;
   } psd_tag_type;
endpackage
`default_nettype wire

// ===== rtl/core/point_segment_distance_top.sv =====
// top level of the point to segment distance block with its output buffer
//
// distance from a query point to a 2-d segment, signed fixed-point coordinates
// req channel: one transaction carries point, segment start and segment end
// rsp channel: one transaction per request with the distance (truncated
//   towards zero, same scale as the inputs), the region and a degenerate flag
// a degenerate segment (start equals end) yields the distance to the start,
//   region beyond start and the flag set
// pipeline: 6 front stages (differences, products, sums, region, partial
//   products, numerator), 65 divider stages (one quotient bit each), 33
//   square-root stages (one root bit each) and the output buffer register
// throughput: one transaction per cycle while the output buffer has room;
//   the pipeline of 104 register stages then takes a new request every cycle
// stalling: a two-entry output buffer sits between the pipeline and rsp;
//   requests keep flowing while a result waits, and only when both entries
//   are occupied does the whole pipeline hold, req_tready low, nothing lost
// reset: synchronous, active high; empties the pipeline and the buffer
`timescale 1ns / 1ps
`default_nettype none
`include "point_segment_distance_top_macros.svh"
module point_segment_distance_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // point_x, point_y, start_x, start_y, end_x, end_y (32 bits each)
   input  logic [psd_pkg::IN_DATA_W-1:0]       req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // dist_res (33 bits), zero padding
   output logic [psd_pkg::OUT_DATA_W-1:0]      rsp_tdata,
   // region (2 bits), degenerate (1 bit)
   output logic [psd_pkg::OUT_USER_W-1:0]      rsp_tuser
);
   import psd_pkg::*;

   // whole pipeline advances while the buffer has room
   logic enable;
   logic full;

   logic             front_valid;
   logic [NUM_W-1:0] front_num;
   logic [SQ_W-1:0]  front_den;
   psd_tag_type      front_tag;

   logic              div_valid;
   logic [QUOT_W-1:0] div_quot;
   psd_tag_type       div_tag;

   logic              sq_valid;
   logic [DIST_W-1:0] sq_root;
   psd_tag_type       sq_tag;

   psd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_tvalid),
      .point_x   (req_tdata[COORD_W-1:0]),
      .point_y   (req_tdata[2*COORD_W-1:COORD_W]),
      .start_x   (req_tdata[3*COORD_W-1:2*COORD_W]),
      .start_y   (req_tdata[4*COORD_W-1:3*COORD_W]),
      .end_x     (req_tdata[5*COORD_W-1:4*COORD_W]),
      .end_y     (req_tdata[6*COORD_W-1:5*COORD_W]),
      .out_valid (front_valid),
      .out_num   (front_num),
      .out_den   (front_den),
      .out_tag   (front_tag)
   );

   // squared distance = numerator / denominator, floored
   psd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (front_valid),
      .in_num    (front_num),
      .in_den    (front_den),
      .in_tag    (front_tag),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_tag   (div_tag)
   );

   psd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (div_valid),
      .in_rad    (div_quot),
      .in_tag    (div_tag),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   // two-entry output buffer
   logic [DIST_W-1:0] dist_ff [2];
   psd_tag_type       tag_ff  [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign full       = (count_ff == 2'd2);
   assign enable     = !full;
   assign req_tready = enable;
   assign push       = enable && sq_valid;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         dist_ff[wr_ptr_ff] <= sq_root;
         tag_ff[wr_ptr_ff]  <= sq_tag;
      end
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = OUT_DATA_W'(dist_ff[rd_ptr_ff]);
   assign rsp_tuser  = {tag_ff[rd_ptr_ff].degenerate, tag_ff[rd_ptr_ff].region};

   `PSD_CHECK(a_count_legal, count_ff != 2'd3, "output buffer count out of range")
   `PSD_IMPLY(a_degen_region, rsp_tvalid && rsp_tuser[2], rsp_tuser[1:0] == REGION_START, "degenerate result not in start region")
   `PSD_IMPLY(a_empty_accepts, !rsp_tvalid, req_tready, "empty buffer but requests refused")
endmodule
`default_nettype wire

// ===== rtl/core/psd_front.sv =====
// front stages: differences, products, sums, region decision and squared numerator
`timescale 1ns / 1ps
`default_nettype none
module psd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                in_valid,
   input  logic signed [psd_pkg::COORD_W-1:0]  point_x,
   input  logic signed [psd_pkg::COORD_W-1:0]  point_y,
   input  logic signed [psd_pkg::COORD_W-1:0]  start_x,
   input  logic signed [psd_pkg::COORD_W-1:0]  start_y,
   input  logic signed [psd_pkg::COORD_W-1:0]  end_x,
   input  logic signed [psd_pkg::COORD_W-1:0]  end_y,
   output logic                                out_valid,
   output logic        [psd_pkg::NUM_W-1:0]    out_num,
   output logic        [psd_pkg::SQ_W-1:0]     out_den,
   output psd_pkg::psd_tag_type                out_tag
);
   import psd_pkg::*;

   // stage 1: differences
   logic signed [DIFF_W-1:0] vx_in, vy_in, ax_in, ay_in, bx_in, by_in;
   logic signed [DIFF_W-1:0] vx_ff, vy_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic degen1_in, degen1_ff, valid1_ff;

   assign vx_in = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
   assign vy_in = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
   assign ax_in = {point_x[COORD_W-1], point_x} - {start_x[COORD_W-1], start_x};
   assign ay_in = {point_y[COORD_W-1], point_y} - {start_y[COORD_W-1], start_y};
   assign bx_in = {point_x[COORD_W-1], point_x} - {end_x[COORD_W-1], end_x};
   assign by_in = {point_y[COORD_W-1], point_y} - {end_y[COORD_W-1], end_y};
   assign degen1_in = (end_x == start_x) && (end_y == start_y);

   // stage 2: products
   logic signed [PROD_W-1:0] pvax_in, pvay_in, pvbx_in, pvby_in, pc1_in, pc2_in;
   logic signed [PROD_W-1:0] paa_in, pab_in, pba_in, pbb_in, pva_in, pvb_in;
   logic signed [PROD_W-1:0] pvax_ff, pvay_ff, pvbx_ff, pvby_ff, pc1_ff, pc2_ff;
   logic signed [PROD_W-1:0] paa_ff, pab_ff, pba_ff, pbb_ff, pva_ff, pvb_ff;
   logic degen2_ff, valid2_ff;

   assign pvax_in = vx_ff * ax_ff;
   assign pvay_in = vy_ff * ay_ff;
   assign pvbx_in = vx_ff * bx_ff;
   assign pvby_in = vy_ff * by_ff;
   assign pc1_in  = ax_ff * vy_ff;
   assign pc2_in  = ay_ff * vx_ff;
   assign paa_in  = ax_ff * ax_ff;
   assign pab_in  = ay_ff * ay_ff;
   assign pba_in  = bx_ff * bx_ff;
   assign pbb_in  = by_ff * by_ff;
   assign pva_in  = vx_ff * vx_ff;
   assign pvb_in  = vy_ff * vy_ff;

   // stage 3: dot products, cross product, squared lengths
   logic signed [DOT_W-1:0] dot1_in, dot2_in, cross_in, dot1_ff, dot2_ff, cross_ff;
   logic [SQ_W-1:0] a2_in, b2_in, l2_in, a2_ff, b2_ff, l2_ff;
   logic degen3_ff, valid3_ff;

   assign dot1_in  = DOT_W'(pvax_ff) + DOT_W'(pvay_ff);
   assign dot2_in  = DOT_W'(pvbx_ff) + DOT_W'(pvby_ff);
   assign cross_in = DOT_W'(pc1_ff) - DOT_W'(pc2_ff);
   // each square is below 2^(2*COORD_W)
   assign a2_in = SQ_W'(paa_ff[PROD_W-3:0]) + SQ_W'(pab_ff[PROD_W-3:0]);
   assign b2_in = SQ_W'(pba_ff[PROD_W-3:0]) + SQ_W'(pbb_ff[PROD_W-3:0]);
   assign l2_in = SQ_W'(pva_ff[PROD_W-3:0]) + SQ_W'(pvb_ff[PROD_W-3:0]);

   // stage 4: region, operand select, cross magnitude
   psd_tag_type tag4_in, tag4_ff;
   logic [SQ_W-1:0]  sq4_in, den4_in, sq4_ff, den4_ff;
   logic [DOT_W-1:0] cross_mag;
   logic [ABS_W-1:0] abs4_ff;
   logic valid4_ff;

   always_comb begin
      tag4_in.degenerate = degen3_ff;
      if (degen3_ff || dot1_ff[DOT_W-1]) begin
         tag4_in.region = REGION_START;
      end else if (!dot2_ff[DOT_W-1] && (dot2_ff != '0)) begin
         tag4_in.region = REGION_END;
      end else begin
         tag4_in.region = REGION_SIDE;
      end
   end

   assign sq4_in    = (tag4_in.region == REGION_END) ? b2_ff : a2_ff;
   assign den4_in   = (tag4_in.region == REGION_SIDE) ? l2_ff : SQ_W'(1);
   assign cross_mag = cross_ff[DOT_W-1] ? (~cross_ff + DOT_W'(1)) : cross_ff;

   // stage 5: partial products of the squared cross magnitude
   logic [ABS_W-1:0] hh_in, hl_in, ll_in, hh_ff, hl_ff, ll_ff;
   logic [SQ_W-1:0]  sq5_ff, den5_ff;
   psd_tag_type tag5_ff;
   logic valid5_ff;

   assign hh_in = abs4_ff[ABS_W-1:HALF_W] * abs4_ff[ABS_W-1:HALF_W];
   assign hl_in = abs4_ff[ABS_W-1:HALF_W] * abs4_ff[HALF_W-1:0];
   assign ll_in = abs4_ff[HALF_W-1:0] * abs4_ff[HALF_W-1:0];

   // stage 6: numerator assembly
   logic [2*ABS_W-1:0] csq;
   logic [NUM_W-1:0]   num6_in, num6_ff;
   logic [SQ_W-1:0]    den6_ff;
   psd_tag_type tag6_ff;
   logic valid6_ff;

   assign csq = ((2*ABS_W)'(hh_ff) << ABS_W) + ((2*ABS_W)'(hl_ff) << (HALF_W + 1))
              + (2*ABS_W)'(ll_ff);
   assign num6_in = (tag5_ff.region == REGION_SIDE) ? csq[NUM_W-1:0] : NUM_W'(sq5_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
         valid6_ff <= valid5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vx_ff <= vx_in;  vy_ff <= vy_in;  ax_ff <= ax_in;
         ay_ff <= ay_in;  bx_ff <= bx_in;  by_ff <= by_in;
         degen1_ff <= degen1_in;
         pvax_ff <= pvax_in;  pvay_ff <= pvay_in;  pvbx_ff <= pvbx_in;
         pvby_ff <= pvby_in;  pc1_ff  <= pc1_in;   pc2_ff  <= pc2_in;
         paa_ff  <= paa_in;   pab_ff  <= pab_in;   pba_ff  <= pba_in;
         pbb_ff  <= pbb_in;   pva_ff  <= pva_in;   pvb_ff  <= pvb_in;
         degen2_ff <= degen1_ff;
         dot1_ff <= dot1_in;  dot2_ff <= dot2_in;  cross_ff <= cross_in;
         a2_ff <= a2_in;  b2_ff <= b2_in;  l2_ff <= l2_in;
         degen3_ff <= degen2_ff;
         tag4_ff <= tag4_in;  sq4_ff <= sq4_in;  den4_ff <= den4_in;
         abs4_ff <= cross_mag[ABS_W-1:0];
         hh_ff <= hh_in;  hl_ff <= hl_in;  ll_ff <= ll_in;
         sq5_ff <= sq4_ff;  den5_ff <= den4_ff;  tag5_ff <= tag4_ff;
         num6_ff <= num6_in;  den6_ff <= den5_ff;  tag6_ff <= tag5_ff;
      end
   end

   assign out_valid = valid6_ff;
   assign out_num   = num6_ff;
   assign out_den   = den6_ff;
   assign out_tag   = tag6_ff;
endmodule
`default_nettype wire

// ===== rtl/core/psd_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module psd_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  logic                            in_valid,
   input  logic [psd_pkg::NUM_W-1:0]       in_num,
   input  logic [psd_pkg::SQ_W-1:0]        in_den,
   input  psd_pkg::psd_tag_type            in_tag,
   output logic                            out_valid,
   output logic [psd_pkg::QUOT_W-1:0]      out_quot,
   output psd_pkg::psd_tag_type            out_tag
);
   import psd_pkg::*;

   logic [SQ_W-1:0]   rem_src [QUOT_W];
   logic [QUOT_W-1:0] lq_src  [QUOT_W];
   logic [SQ_W-1:0]   den_src [QUOT_W];
   psd_tag_type       tag_src [QUOT_W];
   logic [SQ_W-1:0]   rem_in  [QUOT_W];
   logic [QUOT_W-1:0] lq_in   [QUOT_W];
   logic [SQ_W-1:0]   rem_ff  [QUOT_W];
   logic [QUOT_W-1:0] lq_ff   [QUOT_W];
   logic [SQ_W-1:0]   den_ff  [QUOT_W];
   psd_tag_type       tag_ff  [QUOT_W];
   logic [QUOT_W-1:0] valid_ff;

   // quotient fits QUOT_W bits, so the top bits already sit below the divisor
   assign rem_src[0] = in_num[NUM_W-1:QUOT_W];
   assign lq_src[0]  = in_num[QUOT_W-1:0];
   assign den_src[0] = in_den;
   assign tag_src[0] = in_tag;

   for (genvar k = 0; k < QUOT_W; k++) begin : g_step
      logic [SQ_W:0] trial;
      logic          fits;
      if (k > 0) begin : g_link
         assign rem_src[k] = rem_ff[k-1];
         assign lq_src[k]  = lq_ff[k-1];
         assign den_src[k] = den_ff[k-1];
         assign tag_src[k] = tag_ff[k-1];
      end
      assign trial     = {rem_src[k], lq_src[k][QUOT_W-1]};
      assign fits      = trial >= {1'b0, den_src[k]};
      assign rem_in[k] = fits ? SQ_W'(trial - {1'b0, den_src[k]}) : trial[SQ_W-1:0];
      // numerator bits shift out at the top while quotient bits shift in below
      assign lq_in[k]  = {lq_src[k][QUOT_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in[k];
            lq_ff[k]  <= lq_in[k];
            den_ff[k] <= den_src[k];
            tag_ff[k] <= tag_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[QUOT_W-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[QUOT_W-1];
   assign out_quot  = lq_ff[QUOT_W-1];
   assign out_tag   = tag_ff[QUOT_W-1];
endmodule
`default_nettype wire

// ===== rtl/core/psd_sqrt.sv =====
// pipelined digit-by-digit integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module psd_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  logic                            in_valid,
   input  logic [psd_pkg::QUOT_W-1:0]      in_rad,
   input  psd_pkg::psd_tag_type            in_tag,
   output logic                            out_valid,
   output logic [psd_pkg::DIST_W-1:0]      out_root,
   output psd_pkg::psd_tag_type            out_tag
);
   import psd_pkg::*;

   logic [RAD_W-1:0]  rad_src  [DIST_W];
   logic [REM_W-1:0]  rem_src  [DIST_W];
   logic [DIST_W-1:0] root_src [DIST_W];
   psd_tag_type       tag_src  [DIST_W];
   logic [RAD_W-1:0]  rad_ff   [DIST_W];
   logic [REM_W-1:0]  rem_ff   [DIST_W];
   logic [DIST_W-1:0] root_ff  [DIST_W];
   psd_tag_type       tag_ff   [DIST_W];
   logic [DIST_W-1:0] valid_ff;

   assign rad_src[0]  = RAD_W'(in_rad);
   assign rem_src[0]  = '0;
   assign root_src[0] = '0;
   assign tag_src[0]  = in_tag;

   for (genvar k = 0; k < DIST_W; k++) begin : g_step
      logic [REM_W:0]   part;
      logic [REM_W:0]   trial;
      logic             fits;
      logic [REM_W-1:0] rem_in;
      if (k > 0) begin : g_link
         assign rad_src[k]  = rad_ff[k-1];
         assign rem_src[k]  = rem_ff[k-1];
         assign root_src[k] = root_ff[k-1];
         assign tag_src[k]  = tag_ff[k-1];
      end
      // bring down the next two radicand bits
      assign part   = {rem_src[k][REM_W-2:0], rad_src[k][RAD_W-1:RAD_W-2]};
      assign trial  = (REM_W + 1)'({root_src[k], 2'b01});
      assign fits   = part >= trial;
      assign rem_in = fits ? REM_W'(part - trial) : part[REM_W-1:0];

      always_ff @(posedge clock) begin
         if (enable) begin
            rad_ff[k]  <= {rad_src[k][RAD_W-3:0], 2'b00};
            rem_ff[k]  <= rem_in;
            root_ff[k] <= {root_src[k][DIST_W-2:0], fits};
            tag_ff[k]  <= tag_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[DIST_W-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[DIST_W-1];
   assign out_root  = root_ff[DIST_W-1];
   assign out_tag   = tag_ff[DIST_W-1];
endmodule
`default_nettype wire

// ===== tb/psd_checker.sv =====
// checker for the point to segment distance block: predicts each result and compares it
`timescale 1ns / 1ps
module psd_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [psd_pkg::IN_DATA_W-1:0]     req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [psd_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   input  logic [psd_pkg::OUT_USER_W-1:0]    rsp_tuser,
   output int                                fail_count,
   output int                                outstanding
);
   import psd_pkg::*;

   typedef struct packed {
      logic [DIST_W-1:0] dist_res;
      psd_region_type    region;
      logic              degenerate;
   } distance_type;

   distance_type expected_q[$];

   // largest r below 2^DIST_W with r*r*den <= num
   function automatic logic [DIST_W-1:0] root_of_ratio(logic [255:0] num, logic [255:0] den);
      logic [DIST_W-1:0] r;
      logic [DIST_W-1:0] cand;
      logic [255:0]      sq;
      r = '0;
      for (int b = DIST_W - 1; b >= 0; b--) begin
         cand = r | (DIST_W'(1) << b);
         sq = 256'(cand) * 256'(cand) * den;
         if (sq <= num) r = cand;
      end
      return r;
   endfunction

   function automatic distance_type predict_distance(logic [IN_DATA_W-1:0] d);
      logic signed [127:0] px, py, sx, sy, ex, ey;
      logic signed [127:0] vx, vy, ax, ay, bx, by;
      logic signed [127:0] along_start, along_end, cross_prod;
      logic [255:0]        mag2, cross2, len2;
      distance_type        res;
      px = 128'(signed'(d[31:0]));
      py = 128'(signed'(d[63:32]));
      sx = 128'(signed'(d[95:64]));
      sy = 128'(signed'(d[127:96]));
      ex = 128'(signed'(d[159:128]));
      ey = 128'(signed'(d[191:160]));
      vx = ex - sx;  vy = ey - sy;
      ax = px - sx;  ay = py - sy;
      bx = px - ex;  by = py - ey;
      res.degenerate = 1'b0;
      if (vx == 0 && vy == 0) begin
         res.region = REGION_START;
         res.degenerate = 1'b1;
         mag2 = 256'(ax * ax + ay * ay);
         res.dist_res = root_of_ratio(mag2, 256'd1);
      end else begin
         along_start = vx * ax + vy * ay;
         along_end   = vx * bx + vy * by;
         if (along_start < 0) begin
            res.region = REGION_START;
            mag2 = 256'(ax * ax + ay * ay);
            res.dist_res = root_of_ratio(mag2, 256'd1);
         end else if (along_end > 0) begin
            res.region = REGION_END;
            mag2 = 256'(bx * bx + by * by);
            res.dist_res = root_of_ratio(mag2, 256'd1);
         end else begin
            res.region = REGION_SIDE;
            cross_prod = ax * vy - ay * vx;
            if (cross_prod < 0) cross_prod = -cross_prod;
            cross2 = 256'(cross_prod) * 256'(cross_prod);
            len2 = 256'(vx * vx + vy * vy);
            res.dist_res = root_of_ratio(cross2, len2);
         end
      end
      return res;
   endfunction

   assign outstanding = expected_q.size();

   always @(posedge clock) begin
      distance_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_q.push_back(predict_distance(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("result transaction with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[DIST_W-1:0] !== want.dist_res) begin
                  $error("dist_res: expected %0d, got %0d", want.dist_res,
                         rsp_tdata[DIST_W-1:0]);
                  fail_count <= fail_count + 1;
               end
               if (rsp_tuser[1:0] !== want.region) begin
                  $error("region: expected %0d, got %0d", want.region, rsp_tuser[1:0]);
                  fail_count <= fail_count + 1;
               end
               if (rsp_tuser[2] !== want.degenerate) begin
                  $error("degenerate: expected %0d, got %0d", want.degenerate, rsp_tuser[2]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== tb/tb.sv =====
// testbench top for the point to segment distance block: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb;
   import psd_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int DRAIN_CYCLES = 120;   // a little over the pipeline latency

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic [OUT_USER_W-1:0] rsp_tuser;
   int                    fail_count;
   int                    outstanding;
   int                    rsp_seen = 0;
   logic                  steady_mode = 1'b0;  // both sides run without gaps

   always #4 clock = ~clock;

   point_segment_distance_top u_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   psd_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .fail_count, .outstanding
   );

   // point, start, end packed from the lowest bits up
   function automatic logic [IN_DATA_W-1:0] query(int px, int py, int sx, int sy, int ex, int ey);
      return {32'(ey), 32'(ex), 32'(sy), 32'(sx), 32'(py), 32'(px)};
   endfunction

   // coordinate drawn from a mix of full range, shifted-down, small values, extremes and multiples of 2^16
   function automatic int rand_coord();
      case ($urandom_range(0, 5))
         0, 1:    return int'($urandom);
         2:       return $urandom_range(0, 4000) - 2000;
         3:       return int'($urandom) >>> $urandom_range(0, 24);
         4:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return ($urandom_range(0, 200) - 100) <<< 16;
      endcase
   endfunction

   // one request transaction, then the sender's own gap
   task automatic send(logic [IN_DATA_W-1:0] d);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      gap = steady_mode ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // receiver: random stalls, one long hold-off once the run is under way
   initial begin
      int stall;
      bit held = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (!held && rsp_seen >= 300) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);   // pipeline and buffer fill, req stalls
         end else begin
            stall = steady_mode ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_seen++;
      end
   end

   // stimulus and verdict
   initial begin
      int px, py, sx, sy, ex, ey;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, degenerate segments, each region and the boundaries
      send(query(0, 0, 0, 0, 0, 0));
      send(query(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000));
      send(query(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                 32'h7fff_ffff, 32'h8000_0000));
      send(query(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff));
      send(query(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h8000_0000));
      send(query(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                 32'h8000_0000, 32'h7fff_ffff));
      send(query(-5 <<< 16, 1 <<< 16, 0, 0, 10 <<< 16, 0));     // beyond start
      send(query(15 <<< 16, -3 <<< 16, 0, 0, 10 <<< 16, 0));    // beyond end
      send(query(4 <<< 16, 3 <<< 16, 0, 0, 10 <<< 16, 0));      // alongside
      send(query(0, 7 <<< 16, 0, 0, 10 <<< 16, 0));             // projects onto start
      send(query(10 <<< 16, 7 <<< 16, 0, 0, 10 <<< 16, 0));     // projects onto end
      send(query(5, 5, 5, 5, 9, 9));                            // point on start
      send(query(9, 9, 5, 5, 9, 9));                            // point on end
      send(query(7, 7, 5, 5, 9, 9));                            // point on the segment
      send(query(3, 4, 0, 0, 0, 0));                            // degenerate
      send(query(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h8000_0000));
      send(query(1, 2, 0, 0, 3, 7));                            // non-exact root
      send(query(-1, -1, -1, -1, -1, -1));
      send(query(32'h8000_0000, 0, 32'h7fff_ffff, 0, 32'h7fff_ffff, 0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 250 == 0) steady_mode <= ($urandom_range(0, 2) == 0);
         if (n == RANDOM_ITEMS / 2) begin
            // pause until every result is home
            req_tvalid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         px = rand_coord();  py = rand_coord();
         sx = rand_coord();  sy = rand_coord();
         ex = rand_coord();  ey = rand_coord();
         case ($urandom_range(0, 9))
            0: begin ex = sx; ey = sy; end                      // degenerate
            1: begin px = sx; py = sy; end
            2: begin py = sy; ey = sy; end                      // collinear, horizontal
            default: ;
         endcase
         send(query(px, py, sx, sy, ex, ey));
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #4ms;
      $display("tb: errors");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/psd_pkg.sv
rtl/core/psd_front.sv
rtl/core/psd_div.sv
rtl/core/psd_sqrt.sv
rtl/core/point_segment_distance_top.sv
tb/psd_checker.sv
tb/tb.sv
